FILE: src/ppwf_pkg.sv
package ppwf_pkg;

    localparam int unsigned CordicSteps = 18;
    localparam int unsigned CordicW = 34;
    localparam int unsigned ZW = 32;
    localparam logic signed [CordicW-1:0] CordicStart = 34'sd652032874;

    typedef enum logic [2:0] {
        REG_WAVE_X   = 3'd0,
        REG_WAVE_Y   = 3'd1,
        REG_WAVE_Z   = 3'd2,
        REG_OFFSET   = 3'd3,
        REG_COS_AXIS = 3'd4,
        REG_SIN_AXIS = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [CordicW-1:0] x;
        logic signed [CordicW-1:0] y;
        logic signed [ZW-1:0]      z;
        logic [1:0]                q;
    } t_cordic;

    function automatic logic signed [ZW-1:0] atan_turns(input int unsigned i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                0: v = 32'sd536870912;
                1: v = 32'sd316933406;
                2: v = 32'sd167458907;
                3: v = 32'sd85004756;
                4: v = 32'sd42667331;
                5: v = 32'sd21354465;
                6: v = 32'sd10679838;
                7: v = 32'sd5340245;
                8: v = 32'sd2670163;
                9: v = 32'sd1335087;
                10: v = 32'sd667544;
                11: v = 32'sd333772;
                12: v = 32'sd166886;
                13: v = 32'sd83443;
                14: v = 32'sd41722;
                15: v = 32'sd20861;
                16: v = 32'sd10430;
                default: v = 32'sd5215;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: src/ppwf_if.sv
interface ppwf_if #(parameter int unsigned W = 96);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/ppwf_cfg_if.sv
interface ppwf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/ppwf_cordic_step.sv
module ppwf_cordic_step
    import ppwf_pkg::*;
#(
    parameter int unsigned STEP = 0
) (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_cordic i_d,
    output t_cordic o_d
);
    t_cordic r_d;
    t_cordic n_d;
    logic signed [CordicW-1:0] dx;
    logic signed [CordicW-1:0] dy;

    always_comb begin
        dx = i_d.y >>> STEP;
        dy = i_d.x >>> STEP;
        n_d = i_d;
        if (!i_d.z[ZW-1]) begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - atan_turns(STEP);
        end else begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + atan_turns(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_d <= n_d;
    end

    assign o_d = r_d;
endmodule

FILE: src/ppwf_lane.sv
module ppwf_lane (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_wave,
    input  logic signed [31:0] i_pos,
    output logic [63:0]        o_prod
);
    logic [63:0] r_prod;
    always_ff @(posedge i_clk) begin
        if (i_en) r_prod <= 64'(i_wave * i_pos);
    end
    assign o_prod = r_prod;
endmodule

FILE: src/ppwf_out_lane.sv
module ppwf_out_lane (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [33:0] i_c,
    input  logic signed [33:0] i_s,
    input  logic signed [15:0] i_a1,
    input  logic signed [15:0] i_a2,
    output logic signed [15:0] o_field
);
    logic signed [49:0] r_p1;
    logic signed [49:0] r_p2;
    logic signed [15:0] r_f;
    logic signed [50:0] acc;
    logic signed [20:0] sh;

    always_comb begin
        acc = 51'(r_p1) + 51'(r_p2) + (51'sd1 <<< 29);
        sh = 21'(acc >>> 30);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= 50'(i_c * i_a1);
            r_p2 <= 50'(i_s * i_a2);
            if (sh > 21'sd32767) r_f <= 16'sh7fff;
            else if (sh < -21'sd32768) r_f <= 16'sh8000;
            else r_f <= sh[15:0];
        end
    end
    assign o_field = r_f;
endmodule

FILE: src/polarized_plane_wave_field.sv
// The path from accepted input word to valid output word has 24 register stages.
// Throughput: one word per cycle; the pipeline advances whenever its last
// stage is empty or the output word is taken.
// Reset: i_rst_n synchronous active low clears valid bits and configuration registers to 0.
module polarized_plane_wave_field
    import ppwf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    ppwf_cfg_if.sink i_cfg,
    ppwf_if.sink     i_pos,
    ppwf_if.source   o_field
);
    localparam int unsigned Depth = CordicSteps + 6;

    logic [31:0] r_wave [3];
    logic [15:0] r_offset;
    logic [47:0] r_cos;
    logic [47:0] r_sin;
    logic [Depth-1:0] r_vld;
    logic en;

    assign en = !r_vld[Depth-1] || o_field.ready;
    assign i_pos.ready = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave[0] <= '0; r_wave[1] <= '0; r_wave[2] <= '0;
            r_offset <= '0; r_cos <= '0; r_sin <= '0;
            r_vld <= '0;
        end else begin
            if (en) r_vld <= {r_vld[Depth-2:0], i_pos.valid};
            if (i_cfg.valid) begin
                unique case (t_reg_idx'(i_cfg.index))
                    REG_WAVE_X:   r_wave[0] <= i_cfg.data[31:0];
                    REG_WAVE_Y:   r_wave[1] <= i_cfg.data[31:0];
                    REG_WAVE_Z:   r_wave[2] <= i_cfg.data[31:0];
                    REG_OFFSET:   r_offset <= i_cfg.data[15:0];
                    REG_COS_AXIS: r_cos <= i_cfg.data;
                    REG_SIN_AXIS: r_sin <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    logic [63:0] prod [3];
    for (genvar g = 0; g < 3; g++) begin : g_dot
        ppwf_lane u_lane (
            .i_clk(i_clk), .i_en(en),
            .i_wave(r_wave[g]),
            .i_pos(i_pos.data[32*g +: 32]),
            .o_prod(prod[g])
        );
    end

    logic [63:0] r_sum;
    logic [15:0] p;
    logic [15:0] phase;
    logic [1:0]  q;
    logic [15:0] res;
    t_cordic r_c0;
    always_comb begin
        p = 16'((r_sum + 64'd8388608) >> 24);
        phase = p - r_offset;
        q = 2'((phase + 16'h2000) >> 14);
        res = phase - {q, 14'd0};
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum <= prod[0] + prod[1] + prod[2];
            r_c0.x <= CordicStart;
            r_c0.y <= '0;
            r_c0.z <= {res, 16'd0};
            r_c0.q <= q;
        end
    end

    t_cordic st [CordicSteps+1];
    assign st[0] = r_c0;
    for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
        ppwf_cordic_step #(.STEP(g)) u_step (
            .i_clk(i_clk), .i_en(en), .i_d(st[g]), .o_d(st[g+1])
        );
    end

    logic signed [CordicW-1:0] r_c;
    logic signed [CordicW-1:0] r_s;
    t_cordic f;
    assign f = st[CordicSteps];
    always_ff @(posedge i_clk) begin
        if (en) begin
            case (f.q)
                2'd0: begin r_c <= f.x;  r_s <= f.y;  end
                2'd1: begin r_c <= -f.y; r_s <= f.x;  end
                2'd2: begin r_c <= -f.x; r_s <= -f.y; end
                default: begin r_c <= f.y; r_s <= -f.x; end
            endcase
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_out
        ppwf_out_lane u_out (
            .i_clk(i_clk), .i_en(en),
            .i_c(r_c), .i_s(r_s),
            .i_a1(r_cos[16*g +: 16]), .i_a2(r_sin[16*g +: 16]),
            .o_field(o_field.data[16*g +: 16])
        );
    end

    assign o_field.valid = r_vld[Depth-1];

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_field.valid && !o_field.ready |=> o_field.valid)
        else $error("output word dropped");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_field.valid |-> i_pos.ready)
        else $error("stalled with empty output");
    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pos.valid && i_pos.ready |=> r_vld[0])
        else $error("accepted word lost");
`endif
endmodule
